[design/dipa_pkg.sv]
// Package for the dotted IPv4 address parser.
// Holds the classified-character type, the parser state and radix codes, and NUM_EARLY.
// No dependencies.
`timescale 1ns / 1ps

package dipa_pkg;

    typedef struct packed {
        logic       is_nul;
        logic       is_digit;
        logic       is_zero;
        logic       is_hex_letter;
        logic       is_x;
        logic       is_dot;
        logic       is_space;
        logic [3:0] val;
    } t_cls;

    localparam logic [1:0] PH_START  = 2'd0;
    localparam logic [1:0] PH_ZERO   = 2'd1;
    localparam logic [1:0] PH_DIGITS = 2'd2;

    localparam logic [1:0] RX_DEC = 2'd0;
    localparam logic [1:0] RX_OCT = 2'd1;
    localparam logic [1:0] RX_HEX = 2'd2;

    localparam int NUM_EARLY = 3;

endpackage

[design/dipa_front.sv]
// Front end: accepts input characters and classifies them.
// Depends on dipa_pkg; feeds the character queue.
`timescale 1ns / 1ps

module dipa_front (
    input  logic              i_push,
    input  logic [7:0]        i_ch,
    input  logic              i_q_full,
    output logic              o_full,
    output logic              o_wr_en,
    output dipa_pkg::t_cls    o_cls
);
    import dipa_pkg::*;

    logic w_lower;
    logic w_upper;

    assign w_lower = (i_ch >= 8'h61) && (i_ch <= 8'h66);
    assign w_upper = (i_ch >= 8'h41) && (i_ch <= 8'h46);

    assign o_full  = i_q_full;
    assign o_wr_en = i_push && !i_q_full;

    always_comb begin
        o_cls               = '0;
        o_cls.is_nul        = (i_ch == 8'h00);
        o_cls.is_digit      = (i_ch >= 8'h30) && (i_ch <= 8'h39);
        o_cls.is_zero       = (i_ch == 8'h30);
        o_cls.is_hex_letter = w_lower || w_upper;
        o_cls.is_x          = (i_ch == 8'h78) || (i_ch == 8'h58);
        o_cls.is_dot        = (i_ch == 8'h2E);
        o_cls.is_space      = (i_ch == 8'h20) || ((i_ch >= 8'h09) && (i_ch <= 8'h0D));
        if (w_lower || w_upper) begin
            o_cls.val = {1'b0, i_ch[2:0]} + 4'd9;
        end else begin
            o_cls.val = i_ch[3:0];
        end
    end

endmodule

[design/dipa_fifo.sv]
// Short queue of classified characters between front and back.
// Depends on dipa_pkg for the entry type.
`timescale 1ns / 1ps

module dipa_fifo #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  dipa_pkg::t_cls    i_wr_data,
    input  logic              i_rd_en,
    output dipa_pkg::t_cls    o_rd_data,
    output logic              o_full,
    output logic              o_empty
);
    import dipa_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cls            r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_count;
    logic [AW-1:0]   n_wr;
    logic [AW-1:0]   n_rd;
    logic [CW-1:0]   n_count;
    logic            w_wr;
    logic            w_rd;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_wr      = i_wr_en && !o_full;
    assign w_rd      = i_rd_en && !o_empty;
    assign o_rd_data = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (w_wr) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_rd) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr] <= i_wr_data;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count above depth");
    a_count_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr && !w_rd) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not grow on write");
    a_count_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_rd && !w_wr) |=> (r_count == $past(r_count) - 1'b1))
        else $error("queue count did not shrink on read");
`endif

endmodule

[design/dipa_back.sv]
// Back end: runs the part/dot parser over classified characters and
// holds the result register. Depends on dipa_pkg.
`timescale 1ns / 1ps

module dipa_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_avail,
    input  dipa_pkg::t_cls    i_cls,
    output logic              o_take,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [31:0]       o_address,
    output logic              o_valid_res
);
    import dipa_pkg::*;

    logic [1:0]  r_phase;
    logic [1:0]  r_radix;
    logic [31:0] r_pv;
    logic [7:0]  r_parts [NUM_EARLY];
    logic        r_big;
    logic [1:0]  r_pc;
    logic        r_dec;
    logic        r_dok;
    logic [31:0] r_daddr;
    logic        r_out_valid;
    logic [31:0] r_out_addr;
    logic        r_out_ok;

    logic [1:0]  n_phase;
    logic [1:0]  n_radix;
    logic [31:0] n_pv;
    logic [7:0]  n_parts [NUM_EARLY];
    logic        n_big;
    logic [1:0]  n_pc;
    logic        n_dec;
    logic        n_dok;
    logic [31:0] n_daddr;

    logic [1:0]  w_eff_radix;
    logic [31:0] w_scaled;
    logic [31:0] w_acc;
    logic        w_fix;
    logic        w_fix_ok;
    logic        w_fin_fit;
    logic [31:0] w_fin_addr;
    logic        w_res_ok;
    logic [31:0] w_res_addr;
    logic        w_out_free;

    assign w_out_free = !r_out_valid || i_pop;
    assign o_take     = i_avail && (!i_cls.is_nul || w_out_free);
    assign o_empty    = !r_out_valid;
    assign o_address  = r_out_addr;
    assign o_valid_res = r_out_ok;

    assign w_eff_radix = (r_phase == PH_ZERO) ? RX_OCT : r_radix;

    always_comb begin
        case (w_eff_radix)
            RX_HEX:  w_scaled = {r_pv[27:0], 4'b0};
            RX_OCT:  w_scaled = {r_pv[28:0], 3'b0};
            default: w_scaled = {r_pv[28:0], 3'b0} + {r_pv[30:0], 1'b0};
        endcase
    end
    assign w_acc = w_scaled + {28'b0, i_cls.val};

    always_comb begin
        case (r_pc)
            2'd0: begin
                w_fin_fit  = 1'b1;
                w_fin_addr = r_pv;
            end
            2'd1: begin
                w_fin_fit  = (r_pv[31:24] == 8'h00);
                w_fin_addr = {r_parts[0], r_pv[23:0]};
            end
            2'd2: begin
                w_fin_fit  = (r_pv[31:16] == 16'h0000);
                w_fin_addr = {r_parts[0], r_parts[1], r_pv[15:0]};
            end
            default: begin
                w_fin_fit  = (r_pv[31:8] == 24'h000000);
                w_fin_addr = {r_parts[0], r_parts[1], r_parts[2], r_pv[7:0]};
            end
        endcase
    end

    always_comb begin
        n_phase  = r_phase;
        n_radix  = r_radix;
        n_pv     = r_pv;
        n_parts  = r_parts;
        n_big    = r_big;
        n_pc     = r_pc;
        n_dec    = r_dec;
        n_dok    = r_dok;
        n_daddr  = r_daddr;
        w_fix    = 1'b0;
        w_fix_ok = 1'b0;
        case (r_phase)
            PH_START: begin
                if (!i_cls.is_digit) begin
                    w_fix = 1'b1;
                end else if (i_cls.is_zero) begin
                    n_pv    = '0;
                    n_radix = RX_OCT;
                    n_phase = PH_ZERO;
                end else begin
                    n_pv    = {28'b0, i_cls.val};
                    n_radix = RX_DEC;
                    n_phase = PH_DIGITS;
                end
            end
            default: begin
                n_phase = PH_DIGITS;
                n_radix = w_eff_radix;
                if (r_phase == PH_ZERO && i_cls.is_x) begin
                    n_radix = RX_HEX;
                end else if (i_cls.is_digit ||
                             (w_eff_radix == RX_HEX && i_cls.is_hex_letter)) begin
                    n_pv = w_acc;
                end else if (i_cls.is_dot) begin
                    if (r_pc == 2'd3) begin
                        w_fix = 1'b1;
                    end else begin
                        if (r_pv[31:8] != 24'h000000) begin
                            n_big = 1'b1;
                        end
                        n_parts[r_pc] = r_pv[7:0];
                        n_pc          = r_pc + 2'd1;
                        n_pv          = '0;
                        n_radix       = RX_DEC;
                        n_phase       = PH_START;
                    end
                end else if (i_cls.is_nul || i_cls.is_space) begin
                    w_fix    = 1'b1;
                    w_fix_ok = !r_big && w_fin_fit;
                end else begin
                    w_fix = 1'b1;
                end
            end
        endcase
        if (w_fix) begin
            n_dec   = 1'b1;
            n_dok   = w_fix_ok;
            n_daddr = w_fix_ok ? w_fin_addr : '0;
        end
    end

    assign w_res_ok   = r_dec ? r_dok : w_fix_ok;
    assign w_res_addr = r_dec ? r_daddr : (w_fix_ok ? w_fin_addr : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_radix     <= RX_DEC;
            r_pv        <= '0;
            r_parts     <= '{default: '0};
            r_big       <= 1'b0;
            r_pc        <= '0;
            r_dec       <= 1'b0;
            r_dok       <= 1'b0;
            r_daddr     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            if (o_take) begin
                if (i_cls.is_nul) begin
                    r_phase     <= PH_START;
                    r_radix     <= RX_DEC;
                    r_pv        <= '0;
                    r_parts     <= '{default: '0};
                    r_big       <= 1'b0;
                    r_pc        <= '0;
                    r_dec       <= 1'b0;
                    r_dok       <= 1'b0;
                    r_daddr     <= '0;
                    r_out_valid <= 1'b1;
                end else if (!r_dec) begin
                    r_phase <= n_phase;
                    r_radix <= n_radix;
                    r_pv    <= n_pv;
                    r_parts <= n_parts;
                    r_big   <= n_big;
                    r_pc    <= n_pc;
                    r_dec   <= n_dec;
                    r_dok   <= n_dok;
                    r_daddr <= n_daddr;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_cls.is_nul) begin
            r_out_addr <= w_res_addr;
            r_out_ok   <= w_res_ok;
        end
    end

`ifndef ASSERT_OFF
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_ok) |-> (r_out_addr == 32'h0))
        else $error("invalid result carries nonzero address");
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_pop) |=> (r_out_valid && $stable(r_out_addr)
                                     && $stable(r_out_ok)))
        else $error("waiting result changed or dropped");
    a_nul_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && i_cls.is_nul) |=> (r_phase == PH_START && r_pc == 2'd0 && !r_dec))
        else $error("parser not restarted after end of string");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && i_cls.is_nul) |-> (!r_out_valid || i_pop))
        else $error("result register overwritten");
`endif

endmodule

[design/dotted_ipv4_address_parser_top.sv]
// Dotted IPv4 address parser, top level.
// Usage:
//   Input channel: drive one string character on i_ch with push; the
//   transaction completes on a clock edge with push high and full low.
//   A zero byte ends the string. Output channel: while empty is low,
//   o_address and o_valid_res show the result for the oldest finished
//   string; pop high with empty low takes it. One result per string.
//   Result path: a terminating zero byte is queued, then parsed into the
//   result register, after which empty goes low.
//   Throughput: one character per cycle while full is low; the parser
//   takes one queued character per cycle, a terminating byte only when the
//   result register is free or being popped in the same cycle.
//   Stall: with the receiver stalled the queue of FIFO_DEPTH characters
//   fills behind one held result, then full rises.
//   Reset: synchronous, active low; queue and result are emptied and the
//   parser starts a new string.
// Depends on dipa_pkg, dipa_front, dipa_fifo, dipa_back.
`timescale 1ns / 1ps

module dotted_ipv4_address_parser_top #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_ch,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_address,
    output logic        o_valid_res
);
    import dipa_pkg::*;

    t_cls w_cls_in;
    t_cls w_cls_out;
    logic w_wr_en;
    logic w_q_full;
    logic w_q_empty;
    logic w_take;

    dipa_front u_front (
        .i_push   (push),
        .i_ch     (i_ch),
        .i_q_full (w_q_full),
        .o_full   (full),
        .o_wr_en  (w_wr_en),
        .o_cls    (w_cls_in)
    );

    dipa_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_wr_data (w_cls_in),
        .i_rd_en   (w_take),
        .o_rd_data (w_cls_out),
        .o_full    (w_q_full),
        .o_empty   (w_q_empty)
    );

    dipa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_avail     (!w_q_empty),
        .i_cls       (w_cls_out),
        .o_take      (w_take),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_address   (o_address),
        .o_valid_res (o_valid_res)
    );

endmodule
